>>> rtl/cme_pkg.sv
// shared widths, codes and control structs of the moments c/n0 estimator
`timescale 1ns / 1ps
`default_nettype none
package cme_pkg;

  localparam int SMP_W           = 12;
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CNT_W           = 11;
  localparam int ABS_W           = SMP_W;
  localparam int P_W             = 2 * SMP_W;
  localparam int PP_W            = 2 * P_W;
  localparam int S1_W            = ABS_W + CNT_W;
  localparam int S2_W            = P_W + CNT_W;
  localparam int S4_W            = PP_W + CNT_W - 1;
  localparam int WIDE_W          = 88;
  localparam int MA_W            = 64;
  localparam int MB_W            = 44;
  localparam int D_W             = 68;
  localparam int RAD_W           = 84;
  localparam int ROOT_W          = RAD_W / 2;
  localparam int LOG_FRAC        = 24;
  localparam int LP_W            = 7;
  localparam int LOG_W           = LP_W + LOG_FRAC;
  localparam int MANT_W          = 32;
  localparam int LSUM_W          = LOG_W + 2;
  localparam int MAG_W           = 32;
  localparam int DB_W            = 18;
  localparam int PROD_W          = MAG_W + DB_W;
  localparam int COH_W           = 17;
  localparam int CN0_W           = 16;

  localparam logic [COH_W-1:0] COH_RST      = COH_W'(1000);
  localparam logic [DB_W-1:0]  DB_PER_OCT   = DB_W'(197283);
  localparam int               CN0_OFFSET   = 15360;
  localparam int               MOMENT_SHIFT = 16;

  typedef enum logic [2:0] {
    MS_S2SQ,
    MS_NS4,
    MS_NUM,
    MS_S1SQ,
    MS_NS2
  } mul_sel_e;

  typedef enum logic [1:0] {
    LS_NUM,
    LS_DEN,
    LS_TIME
  } log_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     calc_pow;
    logic     acc_12;
    logic     acc_4;
    logic     mul_start;
    logic     mul_store;
    mul_sel_e mul_sel;
    logic     cmp;
    logic     sqrt_start;
    logic     sqrt_store;
    logic     chk;
    logic     log_start;
    logic     log_store;
    log_sel_e log_sel;
    logic     scale;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic win_end;
    logic mul_done;
    logic sqrt_done;
    logic log_done;
    logic cmp_fb;
    logic chk_bad;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/cme_mul.sv
// serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cme_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cme_pkg::MA_W-1:0]   a_i,
  input  wire logic [cme_pkg::MB_W-1:0]   b_i,
  output logic                            done_o,
  output logic [cme_pkg::WIDE_W-1:0]      p_o
);
  import cme_pkg::*;

  logic              busy_q;
  logic [WIDE_W-1:0] a_q;
  logic [MB_W-1:0]   b_q;
  logic [WIDE_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= WIDE_W'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[WIDE_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MB_W-1:1]};
    end
  end

  assign done_o = busy_q && (b_q == '0);
  assign p_o    = acc_q;

endmodule
`default_nettype wire

>>> rtl/cme_sqrt.sv
// restoring integer square root, one root bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cme_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cme_pkg::RAD_W-1:0]  rad_i,
  output logic                            done_o,
  output logic [cme_pkg::ROOT_W-1:0]      root_o
);
  import cme_pkg::*;

  localparam int REM_W = ROOT_W + 4;
  localparam int SC_W  = $clog2(ROOT_W + 1);

  logic              busy_q;
  logic [SC_W-1:0]   cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem2;
  logic [REM_W-1:0]  trial;
  logic              fin;

  assign fin   = busy_q && (cnt_q == SC_W'(ROOT_W));
  assign rem2  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (fin) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + SC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && !fin) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_q  <= rem2 - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem2;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = fin;
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> rtl/cme_log2.sv
// log2 in q24: normalize one bit per cycle, then one squaring per fraction bit
`timescale 1ns / 1ps
`default_nettype none
module cme_log2 (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cme_pkg::WIDE_W-1:0] x_i,
  output logic                            done_o,
  output logic [cme_pkg::LOG_W-1:0]       log_o
);
  import cme_pkg::*;

  localparam int K_W = $clog2(LOG_FRAC + 1);

  logic                  busy_q;
  logic                  norm_q;
  logic [K_W-1:0]        k_q;
  logic [WIDE_W-1:0]     x_q;
  logic [LP_W-1:0]       p_q;
  logic [MANT_W-1:0]     m_q;
  logic [LOG_FRAC-1:0]   frac_q;
  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sh;
  logic                  fin;

  assign fin = busy_q && !norm_q && (k_q == K_W'(LOG_FRAC));
  assign sq  = m_q * m_q;
  assign sh  = sq[2*MANT_W-1 -: MANT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      norm_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      norm_q <= 1'b1;
      k_q    <= '0;
    end else if (fin) begin
      busy_q <= 1'b0;
    end else if (busy_q && norm_q) begin
      if (x_q[WIDE_W-1]) begin
        norm_q <= 1'b0;
      end
    end else if (busy_q) begin
      k_q <= k_q + K_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      p_q    <= LP_W'(WIDE_W - 1);
      frac_q <= '0;
    end else if (busy_q && norm_q) begin
      if (x_q[WIDE_W-1]) begin
        m_q <= x_q[WIDE_W-1 -: MANT_W];
      end else begin
        x_q <= {x_q[WIDE_W-2:0], 1'b0};
        p_q <= p_q - LP_W'(1);
      end
    end else if (busy_q && !fin) begin
      if (sh[MANT_W]) begin
        m_q    <= sh[MANT_W:1];
        frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
      end else begin
        m_q    <= sh[MANT_W-1:0];
        frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
      end
    end
  end

  assign done_o = fin;
  assign log_o  = {p_q, frac_q};

endmodule
`default_nettype wire

>>> rtl/cme_datapath.sv
// accumulators, moment terms, arithmetic units and the result register
`timescale 1ns / 1ps
`default_nettype none
module cme_datapath #(
  parameter int MAX_SAMPLES = cme_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = cme_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [cme_pkg::SMP_W-1:0]   i_sample_i,
  input  wire logic [cme_pkg::SMP_W-1:0]   q_sample_i,
  input  wire logic                        last_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [cme_pkg::COH_W-1:0]   cfg_wdata_i,
  input  wire cme_pkg::cmd_t               cmd_i,
  output cme_pkg::sts_t                    sts_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [cme_pkg::CN0_W-1:0]        cn0_q8_o,
  output logic                             used_fallback_o,
  output logic                             invalid_o
);
  import cme_pkg::*;

  localparam int RND_W = PROD_W + 1;
  localparam int Q_W   = RND_W - 32;
  localparam int V_W   = Q_W + 3;

  logic signed [SAMPLE_BITS-1:0] i_n, q_n;
  logic signed [SMP_W-1:0]       i_q, q_q;
  logic                          last_q;
  logic signed [P_W-1:0]         ii, qq;
  logic [P_W-1:0]                pow_q;
  logic [ABS_W-1:0]              abs_q;
  logic [PP_W-1:0]               pp_q;
  logic [S1_W-1:0]               s1_q;
  logic [S2_W-1:0]               s2_q;
  logic [S4_W-1:0]               s4_q;
  logic [CNT_W-1:0]              n_q;
  logic [COH_W-1:0]              coh_q;

  logic [WIDE_W-1:0]             s2sq_q, ns4_q, num_q, ns2_q, den_q;
  logic                          fb_q, bad_q;
  logic [D_W-1:0]                d_q;
  logic [ROOT_W-1:0]             r_q;
  logic [LOG_W-1:0]              lnum_q, lden_q, lt_q;
  logic                          neg_q;
  logic [PROD_W-1:0]             prod_q;

  logic                          out_valid_q;
  logic [CN0_W-1:0]              out_cn0_q;
  logic                          out_fb_q, out_bad_q;

  logic [MA_W-1:0]               mul_a;
  logic [MB_W-1:0]               mul_b;
  logic [MB_W-1:0]               num_a;
  logic                          mul_done;
  logic [WIDE_W-1:0]             mul_p;
  logic                          sqrt_done;
  logic [ROOT_W-1:0]             sqrt_root;
  logic                          log_done;
  logic [LOG_W-1:0]              log_res;
  logic [WIDE_W-1:0]             log_x;
  logic [COH_W-1:0]              t_us;

  logic [WIDE_W:0]               two_s2sq, diff;
  logic                          cmp_fb;
  logic                          chk_bad;
  logic [WIDE_W-1:0]             chk_den;
  logic signed [LSUM_W-1:0]      lsum;
  logic [MAG_W-1:0]              mag;
  logic [RND_W-1:0]              rnd;
  logic signed [V_W-1:0]         v;
  logic [CN0_W-1:0]              v_sat;

  assign i_n = i_sample_i[SAMPLE_BITS-1:0];
  assign q_n = q_sample_i[SAMPLE_BITS-1:0];
  assign ii  = i_q * i_q;
  assign qq  = q_q * q_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      i_q    <= SMP_W'(i_n);
      q_q    <= SMP_W'(q_n);
      last_q <= last_i;
    end
    if (cmd_i.calc_pow) begin
      pow_q <= P_W'(ii) + P_W'(qq);
      abs_q <= i_q[SMP_W-1] ? ABS_W'(-i_q) : ABS_W'(i_q);
    end
    if (cmd_i.acc_12) begin
      pp_q <= pow_q * pow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      s4_q  <= '0;
      n_q   <= '0;
      coh_q <= COH_RST;
    end else begin
      if (cfg_we_i) begin
        coh_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        s1_q <= '0;
        s2_q <= '0;
        s4_q <= '0;
        n_q  <= '0;
      end else begin
        if (cmd_i.acc_12) begin
          s1_q <= s1_q + S1_W'(abs_q);
          s2_q <= s2_q + S2_W'(pow_q);
        end
        if (cmd_i.acc_4) begin
          s4_q <= s4_q + S4_W'(pp_q);
          n_q  <= n_q + CNT_W'(1);
        end
      end
    end
  end

  assign num_a = MB_W'({s2_q, 8'b0}) + MB_W'(r_q);

  always_comb begin
    case (cmd_i.mul_sel)
      MS_S2SQ: begin
        mul_a = MA_W'(s2_q);
        mul_b = MB_W'(s2_q);
      end
      MS_NS4: begin
        mul_a = MA_W'(s4_q);
        mul_b = MB_W'(n_q);
      end
      MS_NUM: begin
        mul_a = MA_W'(num_a);
        mul_b = MB_W'(r_q);
      end
      MS_S1SQ: begin
        mul_a = MA_W'(s1_q);
        mul_b = MB_W'(s1_q);
      end
      MS_NS2: begin
        mul_a = MA_W'(s2_q);
        mul_b = MB_W'(n_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cme_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  cme_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   ({d_q, MOMENT_SHIFT'(0)}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign t_us = (coh_q == '0) ? COH_W'(1) : coh_q;

  always_comb begin
    case (cmd_i.log_sel)
      LS_NUM:  log_x = num_q;
      LS_DEN:  log_x = den_q;
      LS_TIME: log_x = WIDE_W'(t_us);
      default: log_x = '0;
    endcase
  end

  cme_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  // moment branch test and radicand
  assign two_s2sq = {s2sq_q, 1'b0};
  assign cmp_fb   = {1'b0, ns4_q} > two_s2sq;
  assign diff     = two_s2sq - {1'b0, ns4_q};

  always_comb begin
    if (fb_q) begin
      chk_bad = !(ns2_q > num_q) || (num_q == '0);
      chk_den = ns2_q - num_q;
    end else begin
      chk_bad = !(ns4_q > s2sq_q) || (num_q == '0);
      chk_den = ns4_q - s2sq_q;
    end
  end

  assign lsum = $signed(LSUM_W'(lnum_q)) - $signed(LSUM_W'(lden_q))
              - $signed(LSUM_W'(lt_q))
              - (fb_q ? LSUM_W'(0) : LSUM_W'(MOMENT_SHIFT << LOG_FRAC));
  assign mag  = lsum[LSUM_W-1] ? MAG_W'(-lsum) : MAG_W'(lsum);

  assign rnd = RND_W'(prod_q) + (RND_W'(1) << 31);
  assign v   = (neg_q ? -$signed(V_W'(rnd[RND_W-1:32])) : $signed(V_W'(rnd[RND_W-1:32])))
             + $signed(V_W'(CN0_OFFSET));

  always_comb begin
    if (v > $signed(V_W'(32767))) begin
      v_sat = CN0_W'(32767);
    end else if (v < -$signed(V_W'(32768))) begin
      v_sat = CN0_W'(-32768);
    end else begin
      v_sat = CN0_W'(v);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_store) begin
      case (cmd_i.mul_sel)
        MS_S2SQ: s2sq_q <= mul_p;
        MS_NS4:  ns4_q  <= mul_p;
        MS_NUM:  num_q  <= mul_p;
        MS_S1SQ: num_q  <= mul_p;
        MS_NS2:  ns2_q  <= mul_p;
        default: ;
      endcase
    end
    if (cmd_i.cmp) begin
      fb_q <= cmp_fb;
      d_q  <= diff[D_W-1:0];
    end
    if (cmd_i.sqrt_store) begin
      r_q <= sqrt_root;
    end
    if (cmd_i.chk) begin
      bad_q <= chk_bad;
      den_q <= chk_den;
    end
    if (cmd_i.log_store) begin
      case (cmd_i.log_sel)
        LS_NUM:  lnum_q <= log_res;
        LS_DEN:  lden_q <= log_res;
        LS_TIME: lt_q   <= log_res;
        default: ;
      endcase
    end
    if (cmd_i.scale) begin
      neg_q  <= lsum[LSUM_W-1];
      prod_q <= mag * DB_PER_OCT;
    end
    if (cmd_i.out_load) begin
      out_cn0_q <= bad_q ? '0 : v_sat;
      out_fb_q  <= fb_q;
      out_bad_q <= bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.win_end   = last_q || (n_q == CNT_W'(MAX_SAMPLES));
  assign sts_o.mul_done  = mul_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.log_done  = log_done;
  assign sts_o.cmp_fb    = cmp_fb;
  assign sts_o.chk_bad   = chk_bad;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign cn0_q8_o        = out_cn0_q;
  assign used_fallback_o = out_fb_q;
  assign invalid_o       = out_bad_q;

endmodule
`default_nettype wire

>>> rtl/cme_ctrl.sv
// sequencer for sample accumulation and the end-of-window computation
`timescale 1ns / 1ps
`default_nettype none
module cme_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_tvalid_i,
  output logic                s_tready_o,
  input  wire cme_pkg::sts_t  sts_i,
  output cme_pkg::cmd_t       cmd_o
);
  import cme_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POW,
    ST_ACC,
    ST_ACC4,
    ST_END,
    ST_S2SQ_GO,
    ST_S2SQ_WT,
    ST_NS4_GO,
    ST_NS4_WT,
    ST_CMP,
    ST_SQRT_GO,
    ST_SQRT_WT,
    ST_NUM_GO,
    ST_NUM_WT,
    ST_S1SQ_GO,
    ST_S1SQ_WT,
    ST_NS2_GO,
    ST_NS2_WT,
    ST_CHK,
    ST_LN_GO,
    ST_LN_WT,
    ST_LD_GO,
    ST_LD_WT,
    ST_LT_GO,
    ST_LT_WT,
    ST_SCALE,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;
  logic   ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd     = '0;
    ready   = 1'b0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        ready = 1'b1;
        if (s_tvalid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_POW;
        end
      end
      ST_POW: begin
        cmd.calc_pow = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_12 = 1'b1;
        state_d    = ST_ACC4;
      end
      ST_ACC4: begin
        cmd.acc_4 = 1'b1;
        state_d   = ST_END;
      end
      ST_END: begin
        state_d = sts_i.win_end ? ST_S2SQ_GO : ST_IDLE;
      end
      ST_S2SQ_GO: begin
        cmd.mul_sel   = MS_S2SQ;
        cmd.mul_start = 1'b1;
        state_d       = ST_S2SQ_WT;
      end
      ST_S2SQ_WT: begin
        cmd.mul_sel = MS_S2SQ;
        if (sts_i.mul_done) begin
          cmd.mul_store = 1'b1;
          state_d       = ST_NS4_GO;
        end
      end
      ST_NS4_GO: begin
        cmd.mul_sel   = MS_NS4;
        cmd.mul_start = 1'b1;
        state_d       = ST_NS4_WT;
      end
      ST_NS4_WT: begin
        cmd.mul_sel = MS_NS4;
        if (sts_i.mul_done) begin
          cmd.mul_store = 1'b1;
          state_d       = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        state_d = sts_i.cmp_fb ? ST_S1SQ_GO : ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_d        = ST_SQRT_WT;
      end
      ST_SQRT_WT: begin
        if (sts_i.sqrt_done) begin
          cmd.sqrt_store = 1'b1;
          state_d        = ST_NUM_GO;
        end
      end
      ST_NUM_GO: begin
        cmd.mul_sel   = MS_NUM;
        cmd.mul_start = 1'b1;
        state_d       = ST_NUM_WT;
      end
      ST_NUM_WT: begin
        cmd.mul_sel = MS_NUM;
        if (sts_i.mul_done) begin
          cmd.mul_store = 1'b1;
          state_d       = ST_CHK;
        end
      end
      ST_S1SQ_GO: begin
        cmd.mul_sel   = MS_S1SQ;
        cmd.mul_start = 1'b1;
        state_d       = ST_S1SQ_WT;
      end
      ST_S1SQ_WT: begin
        cmd.mul_sel = MS_S1SQ;
        if (sts_i.mul_done) begin
          cmd.mul_store = 1'b1;
          state_d       = ST_NS2_GO;
        end
      end
      ST_NS2_GO: begin
        cmd.mul_sel   = MS_NS2;
        cmd.mul_start = 1'b1;
        state_d       = ST_NS2_WT;
      end
      ST_NS2_WT: begin
        cmd.mul_sel = MS_NS2;
        if (sts_i.mul_done) begin
          cmd.mul_store = 1'b1;
          state_d       = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.chk = 1'b1;
        state_d = sts_i.chk_bad ? ST_FIN : ST_LN_GO;
      end
      ST_LN_GO: begin
        cmd.log_sel   = LS_NUM;
        cmd.log_start = 1'b1;
        state_d       = ST_LN_WT;
      end
      ST_LN_WT: begin
        cmd.log_sel = LS_NUM;
        if (sts_i.log_done) begin
          cmd.log_store = 1'b1;
          state_d       = ST_LD_GO;
        end
      end
      ST_LD_GO: begin
        cmd.log_sel   = LS_DEN;
        cmd.log_start = 1'b1;
        state_d       = ST_LD_WT;
      end
      ST_LD_WT: begin
        cmd.log_sel = LS_DEN;
        if (sts_i.log_done) begin
          cmd.log_store = 1'b1;
          state_d       = ST_LT_GO;
        end
      end
      ST_LT_GO: begin
        cmd.log_sel   = LS_TIME;
        cmd.log_start = 1'b1;
        state_d       = ST_LT_WT;
      end
      ST_LT_WT: begin
        cmd.log_sel = LS_TIME;
        if (sts_i.log_done) begin
          cmd.log_store = 1'b1;
          state_d       = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cmd_o      = cmd;
  assign s_tready_o = ready;

endmodule
`default_nettype wire

>>> rtl/cn0_moments_estimator_unit.sv
// top level of the moments-method c/n0 estimator
// a sample beat is accepted only in idle, then passes power, two accumulate steps and the window test
// at window end the estimate is computed with the serial 44-bit multiplier,
// the 2-bit-per-cycle square root and the normalize-then-square log2 unit
// the result sits in an output register, so sampling resumes while it waits
// reset clears accumulators and count and sets coh_time_us to 1000; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module cn0_moments_estimator_unit #(
  parameter int MAX_SAMPLES = cme_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = cme_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [2*cme_pkg::SMP_W-1:0] s_axis_tdata_i,  // i_sample, q_sample
  input  wire logic                       s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [cme_pkg::CN0_W-1:0]       m_axis_tdata_o,   // cn0_q8
  output logic [1:0]                      m_axis_tuser_o,   // used_fallback, invalid
  input  wire logic                       cfg_we_i,
  input  wire logic [cme_pkg::COH_W-1:0]  cfg_wdata_i
);
  import cme_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic fb, bad;

  cme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cme_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .i_sample_i      (s_axis_tdata_i[SMP_W-1:0]),
    .q_sample_i      (s_axis_tdata_i[2*SMP_W-1:SMP_W]),
    .last_i          (s_axis_tlast_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .cn0_q8_o        (m_axis_tdata_o),
    .used_fallback_o (fb),
    .invalid_o       (bad)
  );

  assign m_axis_tuser_o = {bad, fb};

endmodule
`default_nettype wire
